// ===== rtl/core/efmd_pkg.sv =====
// Package for the earliest-finish machine dispatcher.
// Word types, machine constants and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package efmd_pkg;

  localparam int unsigned MACHINES  = 8;
  localparam int unsigned MachIdxW  = $clog2(MACHINES);
  localparam int unsigned CountW    = 4;
  localparam int unsigned DurW      = 8;
  localparam int unsigned TimeW     = 32;

  // action codes
  localparam logic ActDispatch = 1'b0;
  localparam logic ActLoad     = 1'b1;

  typedef struct packed {
    logic                action;
    logic [MachIdxW-1:0] machine_index;
    logic [DurW-1:0]     duration;
  } efmd_in_t;

  typedef struct packed {
    logic [TimeW-1:0]    finish_time;
    logic [MachIdxW-1:0] chosen_machine;
  } efmd_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // word taken this cycle
    logic step;     // compare one more machine
    logic commit;   // update free time, fill output register
  } efmd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic item_is_load;  // from the input word, valid with in_valid
    logic single;        // only machine 0 takes part
    logic scan_last;     // current scan index is the last machine
  } efmd_status_t;

endpackage

// ===== rtl/core/efmd_dp.sv =====
// Datapath: duration table, per-machine free times, scan compare unit,
// output word register and machine count register. Depends on efmd_pkg.
`timescale 1ns / 1ps

module efmd_dp import efmd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  efmd_in_t           in_data_i,
  input  efmd_cmd_t          cmd_i,
  output efmd_status_t       status_o,
  input  logic               cfg_we_i,
  input  logic [CountW-1:0]  cfg_data_i,
  output efmd_out_t          out_data_o
);

  logic [TimeW-1:0]    free_time_q [MACHINES];
  logic [DurW-1:0]     dur_tab_q   [MACHINES];

  logic [CountW-1:0]   count_q;
  logic [CountW-1:0]   count_clamped;
  logic [MachIdxW-1:0] last_idx;

  logic [MachIdxW-1:0] scan_idx_q, scan_idx_d;
  logic [TimeW:0]      best_fin_q, best_fin_d;
  logic [DurW-1:0]     best_dur_q, best_dur_d;
  logic [MachIdxW-1:0] best_idx_q, best_idx_d;
  logic                is_load_q;

  logic [MachIdxW-1:0] rd_idx;
  logic [TimeW:0]      cand_fin;
  logic [DurW-1:0]     cand_dur;
  logic                cand_wins;
  logic [TimeW-1:0]    fin_sat;
  efmd_out_t           out_data_q;

  // machine count: zero acts as one, large values clip to the machine total
  always_comb begin
    count_clamped = count_q;
    if (count_q == '0) begin
      count_clamped = CountW'(1);
    end else if (count_q > CountW'(MACHINES)) begin
      count_clamped = CountW'(MACHINES);
    end
  end
  assign last_idx = MachIdxW'(count_clamped - CountW'(1));

  // on accept the scan starts at machine 0, later steps read the scan index
  assign rd_idx   = cmd_i.accept ? '0 : scan_idx_q;
  assign cand_dur = dur_tab_q[rd_idx];
  assign cand_fin = {1'b0, free_time_q[rd_idx]} + {{(TimeW+1-DurW){1'b0}}, cand_dur};
  assign cand_wins = (cand_fin < best_fin_q) ||
                     ((cand_fin == best_fin_q) && (cand_dur > best_dur_q));

  always_comb begin
    scan_idx_d = scan_idx_q;
    best_fin_d = best_fin_q;
    best_dur_d = best_dur_q;
    best_idx_d = best_idx_q;
    if (cmd_i.accept) begin
      scan_idx_d = MachIdxW'(1);
      best_fin_d = cand_fin;
      best_dur_d = cand_dur;
      best_idx_d = '0;
    end else if (cmd_i.step) begin
      scan_idx_d = scan_idx_q + MachIdxW'(1);
      if (cand_wins) begin
        best_fin_d = cand_fin;
        best_dur_d = cand_dur;
        best_idx_d = scan_idx_q;
      end
    end
  end

  assign fin_sat = best_fin_q[TimeW] ? '1 : best_fin_q[TimeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CountW'(1);
      scan_idx_q <= '0;
      is_load_q  <= 1'b0;
      for (int i = 0; i < MACHINES; i++) begin
        free_time_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      scan_idx_q <= scan_idx_d;
      if (cmd_i.accept) begin
        is_load_q <= (in_data_i.action == ActLoad);
      end
      if (cmd_i.commit && !is_load_q) begin
        free_time_q[best_idx_q] <= fin_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_fin_q <= best_fin_d;
    best_dur_q <= best_dur_d;
    best_idx_q <= best_idx_d;
    if (cmd_i.accept && (in_data_i.action == ActLoad)) begin
      dur_tab_q[in_data_i.machine_index] <= in_data_i.duration;
    end
    if (cmd_i.commit) begin
      if (is_load_q) begin
        out_data_q <= '0;
      end else begin
        out_data_q.finish_time    <= fin_sat;
        out_data_q.chosen_machine <= best_idx_q;
      end
    end
  end

  assign out_data_o            = out_data_q;
  assign status_o.item_is_load = (in_data_i.action == ActLoad);
  assign status_o.single       = (last_idx == '0);
  assign status_o.scan_last    = (scan_idx_q == last_idx);

endmodule

// ===== rtl/core/efmd_ctrl.sv =====
// Controller: sequences accept, machine scan and commit, and owns the
// input stall and output valid. Depends on efmd_pkg.
`timescale 1ns / 1ps

module efmd_ctrl import efmd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  efmd_status_t status_i,
  output efmd_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (status_i.item_is_load || status_i.single) ? StDone : StScan;
        end
      end
      StScan: begin
        cmd_o.step = 1'b1;
        if (status_i.scan_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a commit never overwrites a word still waiting at the output
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && out_stall_i))
    else $error("commit while output word pending");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed word not presented");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !status_i.item_is_load && !status_i.single) |=> (state_q == StScan))
    else $error("dispatch with several machines skipped the scan");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && status_i.scan_last) |=> (state_q == StDone))
    else $error("scan ran past the last machine");

endmodule

// ===== rtl/core/earliest_finish_machine_dispatcher.sv =====
// Earliest-finish machine dispatcher: top level joining controller and
// datapath. Depends on efmd_pkg, efmd_ctrl, efmd_dp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): a load word writes
//   one machine's per-job duration; a dispatch word picks, among machines
//   0 .. machine_count-1, the one with least free time plus duration (ties
//   to the longer duration, then the lower index) and advances its free time.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one word per
//   input word; finish time (saturating) and machine, all zero for a load.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): machine_count,
//   always ready; write only while idle.
//   Sequence: a load goes from accept straight to commit; a dispatch steps
//   through the scan (1 .. 8 machines, one compare per cycle through a single
//   add/compare unit) before its commit. Input is held off while a word is
//   in flight; a finished word waits in the output register, and a stalled
//   receiver holds the block in its commit step until the register frees.
//   Reset: free times clear to zero, machine_count to 1; durations are
//   undefined until loaded.
`timescale 1ns / 1ps

module earliest_finish_machine_dispatcher import efmd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  efmd_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output efmd_out_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  efmd_cmd_t    cmd;
  efmd_status_t status;

  assign cfg_ready_o = 1'b1;

  efmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  efmd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/tb_earliest_finish_machine_dispatcher.sv =====
// Testbench for earliest_finish_machine_dispatcher: loads and dispatches jobs
// against its own scheduler predictor and checks every result word.
// Depends on efmd_pkg and the earliest_finish_machine_dispatcher RTL.
`timescale 1ns / 1ps

module tb_earliest_finish_machine_dispatcher;
  import efmd_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  efmd_in_t          in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  efmd_out_t         out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i = '0;

  earliest_finish_machine_dispatcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // scheduler state as the block should hold it
  logic [TimeW-1:0]  free_time_model [MACHINES];
  logic [DurW-1:0]   duration_model [MACHINES];
  logic [CountW-1:0] machine_count_model = 4'd1;

  efmd_in_t  pending_jobs[$];
  efmd_out_t expected_results[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int fail_count = 0;
  int loads_done = 0;
  int dispatches_done = 0;
  int count_settings = 0;

  initial begin
    for (int m = 0; m < MACHINES; m++) begin
      free_time_model[m] = '0;
      duration_model[m] = '0;
    end
  end

  // Apply one word to the predictor and return the word the block must emit.
  function automatic efmd_out_t dispatch_outcome(input efmd_in_t job);
    int unsigned      active;
    int unsigned      best;
    logic [TimeW:0]   best_fin;
    logic [TimeW:0]   fin;
    logic [TimeW-1:0] stored;
    efmd_out_t        res;
    res = '0;
    if (job.action == ActLoad) begin
      duration_model[job.machine_index] = job.duration;
      return res;
    end
    active = 32'(machine_count_model);
    if (active == 0) active = 1;
    if (active > MACHINES) active = MACHINES;
    best = 0;
    best_fin = {1'b0, free_time_model[0]} + (TimeW+1)'(duration_model[0]);
    for (int m = 1; m < active; m++) begin
      fin = {1'b0, free_time_model[m]} + (TimeW+1)'(duration_model[m]);
      // tie: longer duration wins, else lower index stays
      if (fin < best_fin || (fin == best_fin && duration_model[m] > duration_model[best])) begin
        best_fin = fin;
        best = unsigned'(m);
      end
    end
    stored = best_fin[TimeW] ? {TimeW{1'b1}} : best_fin[TimeW-1:0];
    free_time_model[best] = stored;
    res.finish_time = stored;
    res.chosen_machine = best[MachIdxW-1:0];
    return res;
  endfunction

  // input driver: predicts on acceptance, then offers the next queued word
  always @(posedge clk_i or negedge rst_ni) begin : feed_jobs
    logic     next_valid;
    efmd_in_t next_word;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      next_valid = in_valid_i;
      next_word = in_data_i;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(dispatch_outcome(in_data_i));
        if (in_data_i.action == ActLoad) loads_done++;
        else dispatches_done++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_jobs.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        next_word = pending_jobs.pop_front();
        next_valid = 1'b1;
      end
      in_valid_i <= next_valid;
      in_data_i <= next_word;
    end
  end

  // output monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    efmd_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected word: finish_time %0d chosen_machine %0d",
                 out_data_o.finish_time, out_data_o.chosen_machine);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.finish_time !== want.finish_time) begin
            $error("finish_time: expected %0d, got %0d", want.finish_time,
                   out_data_o.finish_time);
            fail_count++;
          end
          if (out_data_o.chosen_machine !== want.chosen_machine) begin
            $error("chosen_machine: expected %0d, got %0d", want.chosen_machine,
                   out_data_o.chosen_machine);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  task automatic push_job(input logic act, input int idx, input int dur);
    efmd_in_t job;
    job.action = act;
    job.machine_index = idx[MachIdxW-1:0];
    job.duration = dur[DurW-1:0];
    pending_jobs.push_back(job);
  endtask

  // hold the sender until every word offered has come back
  task automatic wait_for_quiet();
    while (pending_jobs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_machine_count(input int value);
    wait_for_quiet();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value[CountW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    machine_count_model = value[CountW-1:0];
    count_settings++;
  endtask

  function automatic efmd_in_t random_job();
    efmd_in_t job;
    int       pick;
    job.action = ($urandom_range(0, 99) < 30) ? ActLoad : ActDispatch;
    job.machine_index = MachIdxW'($urandom_range(0, MACHINES - 1));
    pick = $urandom_range(0, 99);
    // mostly short durations so finish times collide and ties get exercised
    if (pick < 2) job.duration = '0;
    else if (pick < 55) job.duration = DurW'($urandom_range(1, 6));
    else if (pick < 62) job.duration = 8'hFF;
    else job.duration = DurW'($urandom_range(1, 255));
    return job;
  endfunction

  int seg_counts[12] = '{8, 2, 0, 15, 1, 5, 8, 9, 3, 7, 4, 6};

  initial begin
    int split;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: machine 0 alone at reset count, then count zero
    push_job(ActLoad, 0, 255);
    push_job(ActDispatch, 0, 0);
    push_job(ActLoad, 0, 1);
    push_job(ActDispatch, 5, 77);
    write_machine_count(0);
    push_job(ActDispatch, 0, 0);
    push_job(ActLoad, 7, 128);
    // all eight machines, walking-one durations, zero duration, ties
    write_machine_count(8);
    push_job(ActLoad, 1, 2);
    push_job(ActLoad, 2, 4);
    push_job(ActLoad, 3, 8);
    push_job(ActLoad, 4, 16);
    push_job(ActLoad, 5, 32);
    push_job(ActLoad, 6, 64);
    push_job(ActLoad, 5, 0);
    push_job(ActDispatch, 0, 0);
    push_job(ActDispatch, 0, 0);
    push_job(ActLoad, 5, 32);
    push_job(ActDispatch, 0, 0);
    push_job(ActDispatch, 0, 0);
    push_job(ActDispatch, 0, 0);
    // count above the machine total saturates
    write_machine_count(15);
    push_job(ActDispatch, 0, 0);
    push_job(ActDispatch, 0, 0);
    push_job(ActDispatch, 0, 0);

    for (int s = 0; s < 12; s++) begin
      write_machine_count(seg_counts[s]);
      if (s < 4) begin
        sender_idle_pct = 30;
        receiver_stall_pct = 72;
      end else if (s < 8) begin
        sender_idle_pct = 72;
        receiver_stall_pct = 30;
      end else begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      split = $urandom_range(10, 60);
      for (int k = 0; k < 70; k++) begin
        if (k == split) wait_for_quiet();
        pending_jobs.push_back(random_job());
      end
    end

    wait_for_quiet();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d loads and %0d dispatches across %0d machine_count writes,",
             loads_done, dispatches_done, count_settings);
    $display("with sender and receiver stalls in turn and a stall-free stretch.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d words outstanding", expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
